// File: rtl/crps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crps_pkg
// shared constants, codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package crps_pkg;

  localparam int SLOT_COUNT  = 16;
  localparam int CHUNK_BYTES = 96;
  localparam int MAX_CHUNKS  = 64;

  localparam int SLOT_W  = $clog2(SLOT_COUNT);
  localparam int FREE_W  = $clog2(SLOT_COUNT + 1);
  localparam int DONE_W  = 4;
  localparam int OFF_W   = 13;
  localparam int SUM_W   = OFF_W + 1;
  localparam int CNT_W   = $clog2(MAX_CHUNKS + 1);
  localparam int CHUNK_W = $clog2(CHUNK_BYTES + 1);
  localparam int UP_W    = SUM_W + CHUNK_W;
  localparam int ADDR_W  = 32;
  localparam int CFG_W   = 32;

  // floor(x / CHUNK_BYTES) as (x * DIV_MUL) >> DIV_SHIFT, exact for x < 2**SUM_W
  localparam int DIV_SHIFT = SUM_W + $clog2(CHUNK_BYTES);
  localparam int DIV_MUL   = ((2 ** DIV_SHIFT) + CHUNK_BYTES - 1) / CHUNK_BYTES;
  localparam int MUL_W     = SUM_W + 1;
  localparam int PROD_W    = SUM_W + MUL_W;

  localparam logic [OFF_W-1:0] SIZE_RESET = OFF_W'(6144);

  typedef enum logic [1:0] {
    REG_BUFFER_BASE   = 2'd0,
    REG_BUFFER_SIZE   = 2'd1,
    REG_STREAM_ENABLE = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    ACT_REPORT = 1'b0,
    ACT_DONE   = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    KIND_ISSUE   = 2'd0,
    KIND_DROP    = 2'd1,
    KIND_RELEASE = 2'd2,
    KIND_NONE    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CLASS_SENT  = 2'd0,
    CLASS_ZERO  = 2'd1,
    CLASS_ERROR = 2'd2
  } class_e;

  typedef enum logic [1:0] {
    RES_NONE    = 2'd0,
    RES_CHUNK   = 2'd1,
    RES_RELEASE = 2'd2
  } res_e;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_EVAL     = 3'd1,
    ST_ALIGN    = 3'd2,
    ST_LOOP_FWD = 3'd3,
    ST_LOOP_BWD = 3'd4
  } state_e;

  typedef struct packed {
    logic load;
    logic align;
    logic chunk;
    logic rewind;
    logic release_slot;
    logic use_size;
    logic out_load;
    res_e res;
    logic last;
    logic misfit;
  } cmd_t;

  typedef struct packed {
    logic enable;
    logic report;
    logic ptr_valid;
    logic off_eq;
    logic off_gt;
    logic slot_ok;
    logic more;
    logic more_next;
    logic misfit_now;
    logic misfit_next;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/capture_ring_packet_slicer_core.sv
`timescale 1ns / 1ps
// result: registered from ST_EVAL for completions, disabled items and equal offsets, from
//   ST_ALIGN for the first report and from the loop states for reports that slice chunks
// throughput: one item at a time, a new item is accepted only in ST_IDLE; a report issues
//   its chunks one chunk beat per cycle while the result register is not stalled
// reset: asynchronous, clears the pointer, frees all slots, loads register defaults
// ----------------------------------------------------------------------------
// capture_ring_packet_slicer_core
// slices a capture ring into fixed chunk transfers over a pool of slots
// ----------------------------------------------------------------------------
module capture_ring_packet_slicer_core
  import crps_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              action_i,
  input  logic [OFF_W-1:0]  capture_offset_i,
  input  logic [DONE_W-1:0] done_slot_i,
  input  logic              xfer_error_i,
  input  logic              zero_length_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        kind_o,
  output logic [ADDR_W-1:0] chunk_address_o,
  output logic [DONE_W-1:0] used_slot_o,
  output logic [FREE_W-1:0] free_slots_o,
  output logic [1:0]        completion_class_o,
  output logic              size_misfit_o,
  output logic              last_o
);

  cmd_t cmd;
  sts_t sts;

  crps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  crps_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .action_i           (action_i),
    .capture_offset_i   (capture_offset_i),
    .done_slot_i        (done_slot_i),
    .xfer_error_i       (xfer_error_i),
    .zero_length_i      (zero_length_i),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .kind_o             (kind_o),
    .chunk_address_o    (chunk_address_o),
    .used_slot_o        (used_slot_o),
    .free_slots_o       (free_slots_o),
    .completion_class_o (completion_class_o),
    .size_misfit_o      (size_misfit_o),
    .last_o             (last_o)
  );

`ifndef SYNTH
  a_drop_only_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_DROP) |-> (free_slots_o == '0))
    else $error("chunk dropped while a slot was free");

  a_misfit_on_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && size_misfit_o |-> last_o)
    else $error("size misfit flagged before the final beat");

  a_release_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_RELEASE) |-> last_o && (free_slots_o != '0))
    else $error("slot release not a lone final beat");
`endif

endmodule

// File: rtl/crps_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crps_ctrl
// sequencer: decodes the held item and, unless the result register stalls, steps the chunk loop one beat a cycle
// ----------------------------------------------------------------------------
module crps_ctrl
  import crps_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   bwd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign bwd        = (state_q == ST_LOOP_BWD);

  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    cmd_o.res       = RES_NONE;
    cmd_o.use_size  = bwd;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (sts_i.out_free) begin
          if (!sts_i.enable) begin
            cmd_o.out_load = 1'b1;
            cmd_o.last     = 1'b1;
            state_d        = ST_IDLE;
          end else if (!sts_i.report) begin
            cmd_o.out_load = 1'b1;
            cmd_o.last     = 1'b1;
            if (sts_i.slot_ok) begin
              cmd_o.release_slot = 1'b1;
              cmd_o.res          = RES_RELEASE;
            end
            state_d = ST_IDLE;
          end else if (!sts_i.ptr_valid) begin
            state_d = ST_ALIGN;
          end else if (sts_i.off_eq) begin
            cmd_o.out_load = 1'b1;
            cmd_o.last     = 1'b1;
            state_d        = ST_IDLE;
          end else if (sts_i.off_gt) begin
            state_d = ST_LOOP_FWD;
          end else begin
            state_d = ST_LOOP_BWD;
          end
        end
      end
      ST_ALIGN: begin
        if (sts_i.out_free) begin
          cmd_o.align    = 1'b1;
          cmd_o.out_load = 1'b1;
          cmd_o.last     = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_LOOP_FWD, ST_LOOP_BWD: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (sts_i.more) begin
            cmd_o.chunk  = 1'b1;
            cmd_o.res    = RES_CHUNK;
            cmd_o.last   = !sts_i.more_next;
            cmd_o.misfit = bwd && !sts_i.more_next && sts_i.misfit_next;
            cmd_o.rewind = bwd && !sts_i.more_next;
            if (!sts_i.more_next) begin
              state_d = ST_IDLE;
            end
          end else begin
            cmd_o.last   = 1'b1;
            cmd_o.misfit = bwd && sts_i.misfit_now;
            cmd_o.rewind = bwd;
            state_d      = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/crps_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crps_datapath
// config registers, item hold, read pointer, slot pool and result register
// ----------------------------------------------------------------------------
module crps_datapath
  import crps_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  input  logic              action_i,
  input  logic [OFF_W-1:0]  capture_offset_i,
  input  logic [DONE_W-1:0] done_slot_i,
  input  logic              xfer_error_i,
  input  logic              zero_length_i,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        kind_o,
  output logic [ADDR_W-1:0] chunk_address_o,
  output logic [DONE_W-1:0] used_slot_o,
  output logic [FREE_W-1:0] free_slots_o,
  output logic [1:0]        completion_class_o,
  output logic              size_misfit_o,
  output logic              last_o
);

  localparam logic [SUM_W-1:0] CHUNK_SUM = SUM_W'(CHUNK_BYTES);

  // configuration
  logic [ADDR_W-1:0] base_q;
  logic [OFF_W-1:0]  size_q;
  logic              en_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      size_q <= SIZE_RESET;
      en_q   <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_BUFFER_BASE:   base_q <= cfg_data_i;
        REG_BUFFER_SIZE:   size_q <= cfg_data_i[OFF_W-1:0];
        REG_STREAM_ENABLE: en_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // held item, offset clamped to the ring
  logic              action_q;
  logic [OFF_W-1:0]  off_q;
  logic [DONE_W-1:0] slot_q;
  logic              err_q;
  logic              zero_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      action_q <= action_i;
      off_q    <= (capture_offset_i > size_q) ? size_q : capture_offset_i;
      slot_q   <= done_slot_i;
      err_q    <= xfer_error_i;
      zero_q   <= zero_length_i;
    end
  end

  // round-up quotient for the first report
  logic [SUM_W-1:0]  div_x;
  logic [PROD_W-1:0] div_prod;
  logic [SUM_W-1:0]  q_q;
  logic [UP_W-1:0]   up;
  logic [OFF_W-1:0]  align_ptr;

  assign div_x    = {1'b0, off_q} + SUM_W'(CHUNK_BYTES - 1);
  assign div_prod = PROD_W'(div_x) * PROD_W'(DIV_MUL);

  always_ff @(posedge clk_i) begin
    q_q <= SUM_W'(div_prod >> DIV_SHIFT);
  end

  assign up        = UP_W'(q_q) * UP_W'(CHUNK_BYTES);
  assign align_ptr = (up > UP_W'(size_q)) ? size_q : up[OFF_W-1:0];

  // read pointer and chunk count
  logic [OFF_W-1:0] rp_q, rp_d;
  logic             pv_q;
  logic [CNT_W-1:0] n_q, n_d;
  logic [SUM_W-1:0] rp_c1, rp_c2, limit;
  logic [CNT_W-1:0] n_inc;

  assign rp_c1 = {1'b0, rp_q} + CHUNK_SUM;
  assign rp_c2 = rp_c1 + CHUNK_SUM;
  assign n_inc = n_q + CNT_W'(1);
  assign limit = cmd_i.use_size ? {1'b0, size_q} : {1'b0, off_q};

  always_comb begin
    rp_d = rp_q;
    n_d  = n_q;
    if (cmd_i.load) begin
      n_d = '0;
    end
    if (cmd_i.chunk) begin
      n_d  = n_inc;
      rp_d = rp_c1[OFF_W-1:0];
    end
    if (cmd_i.align) begin
      rp_d = align_ptr;
    end
    if (cmd_i.rewind) begin
      rp_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q <= '0;
      pv_q <= 1'b0;
      n_q  <= '0;
    end else begin
      rp_q <= rp_d;
      n_q  <= n_d;
      if (cmd_i.align) begin
        pv_q <= 1'b1;
      end
    end
  end

  // slot pool
  logic [SLOT_COUNT-1:0] busy_q, busy_d;
  logic [FREE_W-1:0]     free_q, free_d;
  logic [SLOT_W-1:0]     alloc;
  logic                  avail;
  logic                  slot_in_range;
  logic                  take;

  always_comb begin
    alloc = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!busy_q[i]) begin
        alloc = SLOT_W'(i);
      end
    end
  end

  assign avail         = !(&busy_q);
  assign slot_in_range = ({1'b0, slot_q} < (DONE_W + 1)'(SLOT_COUNT));
  assign take          = cmd_i.chunk && avail;

  always_comb begin
    busy_d = busy_q;
    free_d = free_q;
    if (take) begin
      busy_d[alloc] = 1'b1;
      free_d        = free_q - FREE_W'(1);
    end
    if (cmd_i.release_slot) begin
      busy_d[slot_q[SLOT_W-1:0]] = 1'b0;
      free_d                     = free_q + FREE_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= '0;
      free_q <= FREE_W'(SLOT_COUNT);
    end else begin
      busy_q <= busy_d;
      free_q <= free_d;
    end
  end

  // result register
  logic              out_valid_q;
  kind_e             kind_q, kind_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [DONE_W-1:0] used_q, used_d;
  logic [FREE_W-1:0] free_out_q;
  class_e            class_q, class_d;
  logic              misfit_q;
  logic              last_q;

  always_comb begin
    kind_d  = KIND_NONE;
    addr_d  = '0;
    used_d  = '0;
    class_d = CLASS_SENT;
    unique case (cmd_i.res)
      RES_CHUNK: begin
        kind_d = avail ? KIND_ISSUE : KIND_DROP;
        addr_d = base_q + ADDR_W'(rp_q);
        used_d = avail ? DONE_W'(alloc) : '0;
      end
      RES_RELEASE: begin
        kind_d  = KIND_RELEASE;
        used_d  = slot_q;
        class_d = err_q ? CLASS_ERROR : (zero_q ? CLASS_ZERO : CLASS_SENT);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= cmd_i.out_load || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      kind_q     <= kind_d;
      addr_q     <= addr_d;
      used_q     <= used_d;
      free_out_q <= free_d;
      class_q    <= class_d;
      misfit_q   <= cmd_i.misfit;
      last_q     <= cmd_i.last;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign kind_o             = kind_q;
  assign chunk_address_o    = addr_q;
  assign used_slot_o        = used_q;
  assign free_slots_o       = free_out_q;
  assign completion_class_o = class_q;
  assign size_misfit_o      = misfit_q;
  assign last_o             = last_q;

  // status to the sequencer
  assign sts_o.enable      = en_q;
  assign sts_o.report      = (action_e'(action_q) == ACT_REPORT);
  assign sts_o.ptr_valid   = pv_q;
  assign sts_o.off_eq      = (off_q == rp_q);
  assign sts_o.off_gt      = (off_q > rp_q);
  assign sts_o.slot_ok     = slot_in_range && busy_q[slot_q[SLOT_W-1:0]];
  assign sts_o.more        = (n_q < CNT_W'(MAX_CHUNKS)) && (limit >= rp_c1);
  assign sts_o.more_next   = (n_inc < CNT_W'(MAX_CHUNKS)) && (limit >= rp_c2);
  assign sts_o.misfit_now  = (rp_q != size_q);
  assign sts_o.misfit_next = (rp_c1 != {1'b0, size_q});
  assign sts_o.out_free    = !out_valid_q || !out_stall_i;

endmodule

// File: tb/capture_ring_packet_slicer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// capture_ring_packet_slicer_core_tb
// drives offset reports and completions into the slicer, mirrors the ring
// pointer, slot pool and registers in a behavioural predictor and checks
// every result beat field by field under random idling and back-pressure
// ----------------------------------------------------------------------------
module capture_ring_packet_slicer_core_tb;
  import crps_pkg::*;

  localparam int OFFSET_MAX    = 6143;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES   = 300;
  localparam int QUIET_LIMIT   = 2000;

  typedef struct {
    action_e            action;
    logic [OFF_W-1:0]   offset;
    logic [DONE_W-1:0]  slot;
    logic               err;
    logic               zero;
  } ring_item_t;

  typedef struct {
    kind_e              kind;
    logic [ADDR_W-1:0]  addr;
    logic [DONE_W-1:0]  slot;
    logic [FREE_W-1:0]  free;
    class_e             cls;
    logic               misfit;
    logic               last;
  } slice_beat_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [1:0]        cfg_index_i;
  logic [CFG_W-1:0]  cfg_data_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic              action_i;
  logic [OFF_W-1:0]  capture_offset_i;
  logic [DONE_W-1:0] done_slot_i;
  logic              xfer_error_i;
  logic              zero_length_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [1:0]        kind_o;
  logic [ADDR_W-1:0] chunk_address_o;
  logic [DONE_W-1:0] used_slot_o;
  logic [FREE_W-1:0] free_slots_o;
  logic [1:0]        completion_class_o;
  logic              size_misfit_o;
  logic              last_o;

  // predictor state
  int                   rd_ptr;
  bit                   ptr_aligned;
  bit [SLOT_COUNT-1:0]  slot_taken;
  int                   free_cnt;
  logic [ADDR_W-1:0]    ring_base;
  int                   ring_size;
  bit                   stream_on;

  slice_beat_t expected_slices[$];
  bit          failed;
  int          send_gap_pct;
  int          recv_stall_pct;
  int          hold_left;
  int          quiet_cycles;

  capture_ring_packet_slicer_core i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .action_i           (action_i),
    .capture_offset_i   (capture_offset_i),
    .done_slot_i        (done_slot_i),
    .xfer_error_i       (xfer_error_i),
    .zero_length_i      (zero_length_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .kind_o             (kind_o),
    .chunk_address_o    (chunk_address_o),
    .used_slot_o        (used_slot_o),
    .free_slots_o       (free_slots_o),
    .completion_class_o (completion_class_o),
    .size_misfit_o      (size_misfit_o),
    .last_o             (last_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic slice_beat_t idle_beat(logic misfit);
    slice_beat_t b;
    b.kind   = KIND_NONE;
    b.addr   = '0;
    b.slot   = '0;
    b.free   = FREE_W'(free_cnt);
    b.cls    = CLASS_SENT;
    b.misfit = misfit;
    b.last   = 1'b0;
    return b;
  endfunction

  // lowest free slot wins; with none left the chunk is dropped
  function automatic slice_beat_t take_chunk();
    slice_beat_t b;
    bit          found;
    b      = idle_beat(1'b0);
    b.kind = KIND_DROP;
    b.addr = ring_base + ADDR_W'(rd_ptr);
    found  = 1'b0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (!found && !slot_taken[i]) begin
        found         = 1'b1;
        slot_taken[i] = 1'b1;
        free_cnt--;
        b.kind        = KIND_ISSUE;
        b.slot        = DONE_W'(i);
      end
    end
    b.free = FREE_W'(free_cnt);
    rd_ptr = (rd_ptr + CHUNK_BYTES) & 'h1FFF;
    return b;
  endfunction

  function automatic void predict_slices(ring_item_t it);
    slice_beat_t burst[$];
    slice_beat_t b;
    int          off;
    int          up;
    logic        misfit;
    off = int'(it.offset);
    if (off > ring_size) off = ring_size;
    if (!stream_on) begin
      burst.push_back(idle_beat(1'b0));
    end else if (it.action == ACT_DONE) begin
      if (slot_taken[it.slot]) begin
        slot_taken[it.slot] = 1'b0;
        free_cnt++;
        b      = idle_beat(1'b0);
        b.kind = KIND_RELEASE;
        b.slot = it.slot;
        b.cls  = it.err ? CLASS_ERROR : (it.zero ? CLASS_ZERO : CLASS_SENT);
        burst.push_back(b);
      end else begin
        burst.push_back(idle_beat(1'b0));
      end
    end else if (!ptr_aligned) begin
      up = (off + CHUNK_BYTES - 1) / CHUNK_BYTES * CHUNK_BYTES;
      if (up > ring_size) up = ring_size;
      rd_ptr      = up & 'h1FFF;
      ptr_aligned = 1'b1;
      burst.push_back(idle_beat(1'b0));
    end else if (off == rd_ptr) begin
      burst.push_back(idle_beat(1'b0));
    end else if (off > rd_ptr) begin
      while (burst.size() < MAX_CHUNKS && off - rd_ptr >= CHUNK_BYTES)
        burst.push_back(take_chunk());
      if (burst.size() == 0) burst.push_back(idle_beat(1'b0));
    end else begin
      while (burst.size() < MAX_CHUNKS && rd_ptr <= ring_size &&
             ring_size - rd_ptr >= CHUNK_BYTES)
        burst.push_back(take_chunk());
      misfit = (rd_ptr != ring_size);
      if (burst.size() == 0) burst.push_back(idle_beat(misfit));
      else burst[burst.size()-1].misfit = misfit;
      rd_ptr = 0;
    end
    burst[burst.size()-1].last = 1'b1;
    foreach (burst[i]) expected_slices.push_back(burst[i]);
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      failed = 1'b1;
    end
  endfunction

  always @(posedge clk_i) begin : check_beats
    slice_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_slices.size() == 0) begin
        $error("unexpected result beat: kind %0d address 0x%0h", kind_o, chunk_address_o);
        failed = 1'b1;
      end else begin
        want = expected_slices.pop_front();
        compare_field("kind", want.kind, kind_o);
        compare_field("chunk_address", want.addr, chunk_address_o);
        compare_field("used_slot", want.slot, used_slot_o);
        compare_field("free_slots", want.free, free_slots_o);
        compare_field("completion_class", want.cls, completion_class_o);
        compare_field("size_misfit", want.misfit, size_misfit_o);
        compare_field("last", want.last, last_o);
      end
    end
  end

  // receiver: random stalls, or a counted hold-off when one is requested
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("** capture_ring_packet_slicer_core: FAILED **");
        $finish;
      end
    end
  end

  // all tasks below start and end at a falling edge
  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_BUFFER_BASE:   ring_base = value;
      REG_BUFFER_SIZE:   ring_size = int'(value & 'h1FFF);
      REG_STREAM_ENABLE: stream_on = value[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_item(input ring_item_t it);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    action_i         <= it.action;
    capture_offset_i <= it.offset;
    done_slot_i      <= it.slot;
    xfer_error_i     <= it.err;
    zero_length_i    <= it.zero;
    do @(posedge clk_i); while (in_stall_o);
    predict_slices(it);
    @(negedge clk_i);
  endtask

  task automatic send_report(input int offset);
    ring_item_t it;
    it.action = ACT_REPORT;
    it.offset = OFF_W'(offset);
    it.slot   = DONE_W'($urandom_range(SLOT_COUNT - 1));
    it.err    = $urandom_range(1);
    it.zero   = $urandom_range(1);
    send_item(it);
  endtask

  task automatic send_done(input int slot, input logic err, input logic zero);
    ring_item_t it;
    it.action = ACT_DONE;
    it.offset = OFF_W'($urandom_range(OFFSET_MAX));
    it.slot   = DONE_W'(slot);
    it.err    = err;
    it.zero   = zero;
    send_item(it);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_slices.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic test_disabled_stream();
    write_reg(REG_STREAM_ENABLE, 0);
    send_report(OFFSET_MAX);
    send_done(SLOT_COUNT - 1, 1'b1, 1'b1);
    drain_results();
  endtask

  task automatic test_first_report();
    write_reg(REG_BUFFER_SIZE, 1000);
    write_reg(REG_BUFFER_BASE, 32'h8000_0000);
    write_reg(REG_STREAM_ENABLE, 1);
    send_report(990);
    send_report(OFFSET_MAX);
    send_report(200);
  endtask

  task automatic test_forward_and_wrap();
    send_report(500);
    send_report(1000);
    send_report(OFFSET_MAX);
    send_report(100);
    drain_results();
  endtask

  task automatic test_slot_pool();
    write_reg(REG_BUFFER_SIZE, 6144);
    write_reg(REG_BUFFER_BASE, 32'hFFFF_FFFF);
    send_report(OFFSET_MAX);
    send_done(0, 1'b1, 1'b0);
    send_done(1, 1'b0, 1'b1);
    send_done(2, 1'b1, 1'b1);
    send_done(3, 1'b0, 1'b0);
    send_done(SLOT_COUNT - 1, 1'b0, 1'b0);
    send_done(3, 1'b0, 1'b0);
    send_report(0);
  endtask

  task automatic test_shrunken_ring();
    send_report(3000);
    drain_results();
    write_reg(REG_BUFFER_SIZE, CHUNK_BYTES);
    write_reg(REG_BUFFER_BASE, 0);
    send_report(0);
    send_report(CHUNK_BYTES);
    send_report(50);
    drain_results();
  endtask

  // mostly well-formed reports and completions of busy slots, some noise
  task automatic random_traffic(input int count, input int max_chunks);
    ring_item_t it;
    int         pick;
    int         k;
    int         off;
    repeat (count) begin
      it.action = ACT_REPORT;
      it.offset = OFF_W'($urandom_range(OFFSET_MAX));
      it.slot   = DONE_W'($urandom_range(SLOT_COUNT - 1));
      it.err    = $urandom_range(1);
      it.zero   = $urandom_range(1);
      pick      = $urandom_range(99);
      if (pick < 12) begin
        if ($urandom_range(1)) it.action = ACT_DONE;
      end else if (pick < 55 && free_cnt < SLOT_COUNT) begin
        it.action = ACT_DONE;
        k = $urandom_range(SLOT_COUNT - 1);
        while (!slot_taken[k]) k = (k + 1) % SLOT_COUNT;
        it.slot = DONE_W'(k);
      end else if (pick < 88 || rd_ptr == 0) begin
        off = rd_ptr + CHUNK_BYTES * $urandom_range(max_chunks) +
              $urandom_range(CHUNK_BYTES - 1);
        if (off > OFFSET_MAX) off = OFFSET_MAX;
        it.offset = OFF_W'(off);
      end else begin
        it.offset = OFF_W'($urandom_range(rd_ptr - 1, 0));
      end
      send_item(it);
    end
  endtask

  task automatic test_random_sender_idle();
    send_gap_pct   = 30;
    recv_stall_pct = 56;
    write_reg(REG_BUFFER_BASE, $urandom);
    write_reg(REG_BUFFER_SIZE, 6144);
    random_traffic(40, 5);
    hold_left = HOLD_CYCLES;
    random_traffic(12, 20);
    drain_results();
    random_traffic(40, 5);
    drain_results();
  endtask

  task automatic test_random_receiver_idle();
    send_gap_pct   = 56;
    recv_stall_pct = 30;
    write_reg(REG_BUFFER_BASE, $urandom);
    write_reg(REG_BUFFER_SIZE, $urandom_range(6144, CHUNK_BYTES));
    random_traffic(100, 5);
    drain_results();
  endtask

  task automatic test_random_full_rate();
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    write_reg(REG_BUFFER_BASE, $urandom);
    write_reg(REG_BUFFER_SIZE, CHUNK_BYTES * $urandom_range(MAX_CHUNKS, 1));
    random_traffic(100, 5);
    drain_results();
  endtask

  initial begin
    rst_ni           = 1'b0;
    cfg_valid_i      = 1'b0;
    cfg_index_i      = REG_BUFFER_BASE;
    cfg_data_i       = '0;
    in_valid_i       = 1'b0;
    action_i         = ACT_REPORT;
    capture_offset_i = '0;
    done_slot_i      = '0;
    xfer_error_i     = 1'b0;
    zero_length_i    = 1'b0;
    failed           = 1'b0;
    send_gap_pct     = 30;
    recv_stall_pct   = 56;
    hold_left        = 0;
    rd_ptr           = 0;
    ptr_aligned      = 1'b0;
    slot_taken       = '0;
    free_cnt         = SLOT_COUNT;
    ring_base        = '0;
    ring_size        = 6144;
    stream_on        = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_disabled_stream();
    test_first_report();
    test_forward_and_wrap();
    test_slot_pool();
    test_shrunken_ring();
    test_random_sender_idle();
    test_random_receiver_idle();
    test_random_full_rate();

    drain_results();
    if (!failed && expected_slices.size() == 0)
      $display("** capture_ring_packet_slicer_core: PASSED **");
    else
      $display("** capture_ring_packet_slicer_core: FAILED **");
    $finish;
  end

endmodule
